// ===== hw/rtl/imufd_pkg.sv =====
// ----------------------------------------------------------------------------
// imufd_pkg: shared types and constants for the IMU frame decoder
// Frame layout, type codes, output kind codes and fixed-point scale factors.
// ----------------------------------------------------------------------------
package imufd_pkg;

  // Frame geometry: header, type, 8 payload bytes, checksum.
  localparam int FRAME_BYTES = 11;
  // The checksum byte is never used, so only the first ten bytes are stored.
  localparam int WIN_DEPTH   = FRAME_BYTES - 1;
  localparam int HELD_W      = $clog2(FRAME_BYTES);
  localparam int WORD_W      = 16;
  localparam int VALUE_W     = 32;

  localparam int DEFAULT_FRAC_BITS = 16;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_MASK  = 8'h50;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;

  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_RATE  = 3'd1,
    KIND_ANGLE = 3'd2,
    KIND_MAG   = 3'd3,
    KIND_QUAT  = 3'd4
  } kind_t;

  // Scale factors, round(factor * 2^32). Magnetic (2^32) is a plain shift.
  localparam int K_W = 26;
  localparam logic [K_W-1:0] K_ACCEL = 26'd20573061;
  localparam logic [K_W-1:0] K_RATE  = 26'd4575258;
  localparam logic [K_W-1:0] K_ANGLE = 26'd411773;
  localparam logic [K_W-1:0] K_QUAT  = 26'd131072;

endpackage

// ===== hw/rtl/imufd_scale.sv =====
// ----------------------------------------------------------------------------
// imufd_scale: one payload word to signed fixed point
// Multiplies by the kind's scale constant, rounds half up, keeps 32 bits.
// ----------------------------------------------------------------------------
module imufd_scale #(
  parameter int FRAC_BITS = imufd_pkg::DEFAULT_FRAC_BITS
) (
  input  logic signed [imufd_pkg::WORD_W-1:0]  word,
  input  imufd_pkg::kind_t                     kind,
  output logic signed [imufd_pkg::VALUE_W-1:0] value
);
  import imufd_pkg::*;

  localparam int SHIFT_BITS = VALUE_W - FRAC_BITS;
  localparam int PROD_W     = WORD_W + K_W + 1;

  logic [K_W-1:0]             k_sel;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [PROD_W-1:0]   prod_shr;

  always_comb begin
    case (kind)
      KIND_ACCEL: k_sel = K_ACCEL;
      KIND_RATE:  k_sel = K_RATE;
      KIND_ANGLE: k_sel = K_ANGLE;
      KIND_QUAT:  k_sel = K_QUAT;
      default:    k_sel = '0;
    endcase
  end

  assign prod     = PROD_W'(word) * $signed({1'b0, k_sel});
  assign prod_rnd = prod + (PROD_W'(1) <<< (SHIFT_BITS - 1));
  assign prod_shr = prod_rnd >>> SHIFT_BITS;

  // Magnetic words are raw: scale by exactly 2^FRAC_BITS.
  always_comb begin
    if (kind == KIND_MAG) begin
      value = VALUE_W'(word) <<< FRAC_BITS;
    end else begin
      value = prod_shr[VALUE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/imu_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// imu_frame_decoder_core: byte-serial parser for 11-byte IMU frames
// Slides a window over received bytes, checks header and type, and emits
// scaled Q(32-FRAC_BITS).FRAC_BITS values for known frame types.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_valid / in_stall  | in_rx_byte[7:0]
//  out_    | out | out_valid / out_stall| out_frame_kind[2:0], out_value_x/y/z/w
//
// One byte beat is taken per cycle while in_stall is low; the beat closing a
// good frame loads the frame register, and the result then passes through the
// multiply-and-round into the output register.
// rst_n (synchronous, active low) empties the window and both stages.
// in_stall rises only when the frame register is full and cannot move into
// an output register that is itself held by out_stall.
// ----------------------------------------------------------------------------
module imu_frame_decoder_core #(
  parameter int FRAC_BITS = imufd_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_frame_kind,
  output logic signed [imufd_pkg::VALUE_W-1:0] out_value_x,
  output logic signed [imufd_pkg::VALUE_W-1:0] out_value_y,
  output logic signed [imufd_pkg::VALUE_W-1:0] out_value_z,
  output logic signed [imufd_pkg::VALUE_W-1:0] out_value_w
);
  import imufd_pkg::*;

  localparam int NWORDS = 4;

  // Byte window: entries 0..WIN_DEPTH-1, filled in order.
  logic [7:0]        win_r   [WIN_DEPTH];
  logic [7:0]        win_nxt [WIN_DEPTH];
  logic [HELD_W-1:0] held_r, held_nxt;

  // Frame register between window and scaler.
  logic                     frm_valid_r, frm_valid_nxt;
  kind_t                    frm_kind_r;
  logic signed [WORD_W-1:0] frm_word_r [NWORDS];

  // Output register.
  logic                      out_valid_r;
  kind_t                     out_kind_r;
  logic signed [VALUE_W-1:0] out_val_r [NWORDS];

  logic                      in_acc;
  logic                      out_ready;
  logic                      frm_ready;
  logic                      full;
  logic                      hdr_ok;
  logic                      type_known;
  kind_t                     type_kind;
  logic                      cap;
  logic signed [VALUE_W-1:0] scaled [NWORDS];

  // Pipeline flow: each stage moves when the one after it can take it.
  assign out_ready = !out_valid_r || !out_stall;
  assign frm_ready = !frm_valid_r || out_ready;
  assign in_stall  = !frm_ready;
  assign in_acc    = in_valid && !in_stall;

  // The window is full once ten bytes sit in it; the incoming byte is the
  // checksum slot; the checksum is never verified.
  assign full   = held_r >= HELD_W'(WIN_DEPTH);
  assign hdr_ok = (win_r[0] == HDR_BYTE) && ((win_r[1] & TYPE_MASK) == TYPE_MASK);

  always_comb begin
    type_known = 1'b1;
    case (win_r[1])
      TYPE_ACCEL: type_kind = KIND_ACCEL;
      TYPE_RATE:  type_kind = KIND_RATE;
      TYPE_ANGLE: type_kind = KIND_ANGLE;
      TYPE_MAG:   type_kind = KIND_MAG;
      TYPE_QUAT:  type_kind = KIND_QUAT;
      default: begin
        type_known = 1'b0;
        type_kind  = KIND_ACCEL;
      end
    endcase
  end

  // Window update: append, consume a good frame, or drop the oldest byte.
  always_comb begin
    win_nxt  = win_r;
    held_nxt = held_r;
    cap      = 1'b0;
    if (in_acc) begin
      if (!full) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (held_r == HELD_W'(i)) begin
            win_nxt[i] = in_rx_byte;
          end
        end
        held_nxt = held_r + HELD_W'(1);
      end else if (hdr_ok) begin
        // Good header: frame consumed; unknown types give no result.
        held_nxt = '0;
        cap      = type_known;
      end else begin
        // Bad header: slide by one, the new byte lands in the last slot.
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_DEPTH-1] = in_rx_byte;
        held_nxt             = HELD_W'(WIN_DEPTH);
      end
    end
  end

  always_comb begin
    frm_valid_nxt = frm_valid_r;
    if (frm_ready) begin
      frm_valid_nxt = cap;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      held_r      <= '0;
      frm_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      frm_valid_r <= frm_valid_nxt;
      if (out_ready) begin
        out_valid_r <= frm_valid_r;
      end
    end
  end

  // Payload words are little endian, starting at byte 2.
  always_ff @(posedge clk) begin
    if (cap) begin
      frm_kind_r <= type_kind;
      for (int i = 0; i < NWORDS; i++) begin
        frm_word_r[i] <= {win_r[2*i+3], win_r[2*i+2]};
      end
    end
  end

  for (genvar g = 0; g < NWORDS; g++) begin : g_scale
    imufd_scale #(
      .FRAC_BITS (FRAC_BITS)
    ) u_scale (
      .word  (frm_word_r[g]),
      .kind  (frm_kind_r),
      .value (scaled[g])
    );
  end

  always_ff @(posedge clk) begin
    if (out_ready && frm_valid_r) begin
      out_kind_r   <= frm_kind_r;
      out_val_r[0] <= scaled[0];
      out_val_r[1] <= scaled[1];
      out_val_r[2] <= scaled[2];
      // Fourth component only exists for quaternion frames.
      out_val_r[3] <= (frm_kind_r == KIND_QUAT) ? scaled[3] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = out_kind_r;
  assign out_value_x    = out_val_r[0];
  assign out_value_y    = out_val_r[1];
  assign out_value_z    = out_val_r[2];
  assign out_value_w    = out_val_r[3];

endmodule
